>>> rtl/assert_macros.svh
// Assertion macros for the SHA-1 engine RTL (used by sha1_ctrl).
// Depends on nothing; compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SHA1_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sha1 assertion failed");
`define SHA1_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("sha1 forbidden condition");
`else
`define SHA1_ASSERT(lbl, clk, rst_n, prop)
`define SHA1_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

>>> rtl/sha1_pkg.sv
// Types, constants and round functions for the SHA-1 engine.
// Used by sha1_ctrl, sha1_dp and sha1_hash_engine.
package sha1_pkg;

  localparam int BlockWords = 16;
  localparam int HashWords  = 5;
  localparam logic [6:0] RndLast   = 7'd79;
  localparam logic [5:0] FillLast  = 6'd63;
  localparam logic [5:0] FillLenAt = 6'd56;
  localparam logic [7:0] PadByte   = 8'h80;

  typedef enum logic [3:0] {
    S_IDLE, S_DATA, S_PAD80, S_ZERO, S_LEN, S_COMP, S_FINAL, S_DIGEST
  } state_t;

  typedef enum logic [1:0] {BSEL_DATA, BSEL_PAD, BSEL_ZERO, BSEL_LEN} bsel_t;

  typedef struct packed {
    logic       load_in;
    logic       put_en;
    bsel_t      bsel;
    logic [2:0] bidx;
    logic       msg_inc;
    logic       init_abcde;
    logic       rnd_en;
    logic [6:0] rnd;
    logic       add_hash;
    logic       load_dig;
  } cmd_t;

  typedef struct packed {
    logic [5:0] fill;
    logic [2:0] n;
    logic       last;
    logic       out_busy;
  } status_t;

  function automatic logic [31:0] init_hash(input logic [2:0] idx);
    logic [31:0] v;
    case (idx)
      3'd0:    v = 32'h67452301;
      3'd1:    v = 32'hefcdab89;
      3'd2:    v = 32'h98badcfe;
      3'd3:    v = 32'h10325476;
      default: v = 32'hc3d2e1f0;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] round_k(input logic [6:0] rnd);
    logic [31:0] k;
    if (rnd < 7'd20)      k = 32'h5a827999;
    else if (rnd < 7'd40) k = 32'h6ed9eba1;
    else if (rnd < 7'd60) k = 32'h8f1bbcdc;
    else                  k = 32'hca62c1d6;
    return k;
  endfunction

  function automatic logic [31:0] round_f(input logic [6:0] rnd, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    if (rnd < 7'd20)      f = (b & c) | (~b & d);
    else if (rnd < 7'd40) f = b ^ c ^ d;
    else if (rnd < 7'd60) f = (b & c) | (b & d) | (c & d);
    else                  f = b ^ c ^ d;
    return f;
  endfunction

endpackage

>>> rtl/sha1_dp.sv
// SHA-1 datapath: input word, block buffer / schedule window, round
// registers, chaining values and digest output stage. Uses sha1_pkg.
module sha1_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  sha1_pkg::cmd_t      cmd,
  output sha1_pkg::status_t   status,
  input  logic [31:0]         in_data_word,
  input  logic [2:0]          in_byte_count,
  input  logic                in_last,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [31:0]         out_digest_word,
  output logic                out_digest_last
);
  import sha1_pkg::*;

  logic [31:0] data_r;
  logic [2:0]  n_r;
  logic        last_r;
  logic [31:0] blk_r [BlockWords];
  logic [5:0]  fill_r;
  logic [60:0] msg_r;
  logic [31:0] h_r [HashWords];
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [31:0] dig_r [HashWords];
  logic [2:0]  ocnt_r;
  logic        obusy_r;

  logic [7:0]  put_byte;
  logic [63:0] bits;
  logic [4:0]  lane_sh;
  logic [31:0] w_new;
  logic [31:0] t_sum;
  logic        out_take;

  assign bits    = {msg_r, 3'b000};
  assign lane_sh = {~fill_r[1:0], 3'b000};
  assign w_new   = blk_r[13] ^ blk_r[8] ^ blk_r[2] ^ blk_r[0];
  assign t_sum   = {a_r[26:0], a_r[31:27]} + round_f(cmd.rnd, b_r, c_r, d_r) + e_r
                   + blk_r[0] + round_k(cmd.rnd);
  assign out_take = obusy_r && !out_stall;

  always_comb begin
    case (cmd.bsel)
      BSEL_DATA: put_byte = data_r[{~cmd.bidx[1:0], 3'b000} +: 8];
      BSEL_PAD:  put_byte = PadByte;
      BSEL_LEN:  put_byte = bits[{~cmd.bidx, 3'b000} +: 8];
      default:   put_byte = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      data_r <= in_data_word;
      n_r    <= (in_byte_count > 3'd4) ? 3'd4 : in_byte_count;
      last_r <= in_last;
    end
    if (cmd.put_en) begin
      blk_r[fill_r[5:2]][lane_sh +: 8] <= put_byte;
    end else if (cmd.rnd_en) begin
      // slide the schedule window by one word
      for (int i = 0; i < BlockWords - 1; i++) blk_r[i] <= blk_r[i + 1];
      blk_r[BlockWords - 1] <= {w_new[30:0], w_new[31]};
    end
    if (cmd.init_abcde) begin
      a_r <= h_r[0];
      b_r <= h_r[1];
      c_r <= h_r[2];
      d_r <= h_r[3];
      e_r <= h_r[4];
    end else if (cmd.rnd_en) begin
      a_r <= t_sum;
      b_r <= a_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      d_r <= c_r;
      e_r <= d_r;
    end
    if (cmd.load_dig) begin
      for (int i = 0; i < HashWords; i++) dig_r[i] <= h_r[i];
    end else if (out_take) begin
      for (int i = 0; i < HashWords - 1; i++) dig_r[i] <= dig_r[i + 1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      msg_r   <= '0;
      ocnt_r  <= '0;
      obusy_r <= 1'b0;
      for (int i = 0; i < HashWords; i++) h_r[i] <= init_hash(3'(i));
    end else begin
      if (cmd.load_dig) begin
        fill_r <= '0;
        msg_r  <= '0;
        for (int i = 0; i < HashWords; i++) h_r[i] <= init_hash(3'(i));
      end else begin
        if (cmd.put_en) fill_r <= fill_r + 6'd1;
        if (cmd.msg_inc) msg_r <= msg_r + 61'd1;
        if (cmd.add_hash) begin
          h_r[0] <= h_r[0] + a_r;
          h_r[1] <= h_r[1] + b_r;
          h_r[2] <= h_r[2] + c_r;
          h_r[3] <= h_r[3] + d_r;
          h_r[4] <= h_r[4] + e_r;
        end
      end
      if (cmd.load_dig) begin
        obusy_r <= 1'b1;
        ocnt_r  <= '0;
      end else if (out_take) begin
        ocnt_r <= ocnt_r + 3'd1;
        if (ocnt_r == 3'd4) obusy_r <= 1'b0;
      end
    end
  end

  assign status.fill     = fill_r;
  assign status.n        = n_r;
  assign status.last     = last_r;
  assign status.out_busy = obusy_r;

  assign out_valid       = obusy_r;
  assign out_digest_word = dig_r[0];
  assign out_digest_last = (ocnt_r == 3'd4);

endmodule

>>> rtl/sha1_ctrl.sv
// SHA-1 controller: sequences byte packing, padding, the 80 rounds and
// the digest hand-off. Uses sha1_pkg and assert_macros.svh.
`include "assert_macros.svh"
module sha1_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sha1_pkg::status_t  status,
  output sha1_pkg::cmd_t     cmd
);
  import sha1_pkg::*;

  state_t     state_r, state_nxt;
  state_t     ret_r, ret_nxt;
  logic [2:0] bi_r, bi_nxt;
  logic [6:0] rnd_r, rnd_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= S_IDLE;
      bi_r    <= '0;
      rnd_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      bi_r    <= bi_nxt;
      rnd_r   <= rnd_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    bi_nxt    = bi_r;
    rnd_nxt   = rnd_r;
    cmd       = '0;
    cmd.bsel  = BSEL_ZERO;
    cmd.rnd   = rnd_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          bi_nxt      = '0;
          state_nxt   = S_DATA;
        end
      end
      S_DATA: begin
        if (bi_r == status.n) begin
          state_nxt = status.last ? S_PAD80 : S_IDLE;
        end else begin
          cmd.put_en  = 1'b1;
          cmd.bsel    = BSEL_DATA;
          cmd.bidx    = bi_r;
          cmd.msg_inc = 1'b1;
          bi_nxt      = bi_r + 3'd1;
          if (status.fill == FillLast) begin
            ret_nxt   = S_DATA;
            state_nxt = S_COMP;
          end
        end
      end
      S_PAD80: begin
        cmd.put_en = 1'b1;
        cmd.bsel   = BSEL_PAD;
        state_nxt  = S_ZERO;
        if (status.fill == FillLast) begin
          ret_nxt   = S_ZERO;
          state_nxt = S_COMP;
        end
      end
      S_ZERO: begin
        if (status.fill == FillLenAt) begin
          bi_nxt    = '0;
          state_nxt = S_LEN;
        end else begin
          cmd.put_en = 1'b1;
          if (status.fill == FillLast) begin
            ret_nxt   = S_ZERO;
            state_nxt = S_COMP;
          end
        end
      end
      S_LEN: begin
        cmd.put_en = 1'b1;
        cmd.bsel   = BSEL_LEN;
        cmd.bidx   = bi_r;
        bi_nxt     = bi_r + 3'd1;
        if (status.fill == FillLast) begin
          ret_nxt   = S_DIGEST;
          state_nxt = S_COMP;
        end
      end
      S_COMP: begin
        cmd.rnd_en = 1'b1;
        rnd_nxt    = rnd_r + 7'd1;
        if (rnd_r == RndLast) state_nxt = S_FINAL;
      end
      S_FINAL: begin
        cmd.add_hash = 1'b1;
        state_nxt    = ret_r;
      end
      S_DIGEST: begin
        // hold until the previous digest has drained
        if (!status.out_busy) begin
          cmd.load_dig = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    // load the working registers as the block completes
    if (state_nxt == S_COMP && state_r != S_COMP) begin
      cmd.init_abcde = 1'b1;
      rnd_nxt        = '0;
    end
  end

  `SHA1_ASSERT(a_rnd_end, clk, rst_n, (state_r == S_COMP && rnd_r == RndLast) |=> (state_r == S_FINAL))
  `SHA1_ASSERT(a_comp_fill, clk, rst_n, (state_r == S_COMP) |-> (status.fill == 6'd0))
  `SHA1_NEVER(a_bi_range, clk, rst_n, (state_r == S_DATA && bi_r > status.n))
  `SHA1_ASSERT(a_dig_free, clk, rst_n, cmd.load_dig |-> !status.out_busy)

endmodule

>>> rtl/sha1_hash_engine.sv
// A word is accepted, then its valid bytes are packed one at a time into the block buffer; each
// full block runs the 80 rounds, one per cycle, then the chaining add. The last word adds a
// pad byte, byte-serial zero fill and the 64-bit length, then the digest hand-off.
// A new word is taken only once the previous word and any padding, compression or digest hand-off
// it led to are done, so throughput is set by byte-serial packing and the single shared round unit.
// Digest words drain from their own register while the next message is taken.
// Reset (synchronous, rst_n low) restores initial chaining values and empties all counters.
module sha1_hash_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_data_word,
  input  logic [2:0]  in_byte_count,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic        out_digest_last
);
  import sha1_pkg::*;

  cmd_t    cmd;
  status_t status;

  sha1_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  sha1_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_data_word    (in_data_word),
    .in_byte_count   (in_byte_count),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_digest_word (out_digest_word),
    .out_digest_last (out_digest_last)
  );

endmodule
